// ===== hdl/ptlr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptlr_pkg: shared types and codes for the page translation block
// Beat structs, command and status codes, controller command/status bundles.
// ----------------------------------------------------------------------------
package ptlr_pkg;

	localparam logic [1:0] CMD_READ  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_EXEC  = 2'd2;
	localparam logic [1:0] CMD_LOAD  = 2'd3;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_BOUNDS  = 3'd1;
	localparam logic [2:0] ST_OWNER   = 3'd2;
	localparam logic [2:0] ST_DENY_RD = 3'd3;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [1:0]  process_id;
		logic [2:0]  table_index;
		logic [15:0] virt_addr;
		logic [2:0]  protection;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [6:0] phys_addr;
		logic       page_fault;
		logic [9:0] fill_aux_addr;
		logic       evicted;
		logic       writeback;
		logic [9:0] evict_aux_addr;
	} rsp_t;

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_LOOKUP = 8'b0000_0010,
		S_CHECK  = 8'b0000_0100,
		S_FSCAN  = 8'b0000_1000,
		S_ESCAN  = 8'b0001_0000,
		S_EVICT  = 8'b0010_0000,
		S_FINISH = 8'b0100_0000,
		S_OUT    = 8'b1000_0000
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;   // latch request
		logic lookup;    // read entry at request index
		logic finish;    // update entry, build result
		logic scan_clr;  // reset scan counter and flags
		logic fscan;     // step frame scan
		logic escan;     // step entry scan
		logic evict;     // read victim entry
		logic use_free;  // fault took a free frame
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic oob;
		logic is_load;
		logic not_owner;
		logic resident;
		logic fscan_hit;
		logic fscan_done;
		logic escan_done;
	} sts_t;

endpackage

// ===== hdl/ptlr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptlr_ctrl: sequencer for lookup, frame scan, victim scan and update
// One-hot state machine issuing datapath commands and owning the handshakes.
// ----------------------------------------------------------------------------
module ptlr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  ptlr_pkg::sts_t    sts,
	output ptlr_pkg::ctl_t    ctl
);
	ptlr_pkg::state_t state_q, state_d;
	logic             use_free_q, use_free_d;

	assign in_stall  = (state_q != ptlr_pkg::S_IDLE);
	assign out_valid = (state_q == ptlr_pkg::S_OUT);

	always_comb begin
		state_d    = state_q;
		use_free_d = use_free_q;
		ctl        = '0;
		ctl.use_free = use_free_q;
		unique case (state_q)
			ptlr_pkg::S_IDLE: begin
				if (in_valid) begin
					ctl.capture = 1'b1;
					state_d     = ptlr_pkg::S_LOOKUP;
				end
			end
			ptlr_pkg::S_LOOKUP: begin
				ctl.lookup = 1'b1;
				state_d    = ptlr_pkg::S_CHECK;
			end
			ptlr_pkg::S_CHECK: begin
				ctl.scan_clr = 1'b1;
				use_free_d   = 1'b0;
				if (sts.oob || sts.is_load || sts.not_owner || sts.resident)
					state_d = ptlr_pkg::S_FINISH;
				else
					state_d = ptlr_pkg::S_FSCAN;
			end
			ptlr_pkg::S_FSCAN: begin
				ctl.fscan = 1'b1;
				if (sts.fscan_hit) begin
					use_free_d = 1'b1;
					state_d    = ptlr_pkg::S_FINISH;
				end else if (sts.fscan_done) begin
					ctl.scan_clr = 1'b1;
					state_d      = ptlr_pkg::S_ESCAN;
				end
			end
			ptlr_pkg::S_ESCAN: begin
				ctl.escan = 1'b1;
				if (sts.escan_done) state_d = ptlr_pkg::S_EVICT;
			end
			ptlr_pkg::S_EVICT: begin
				ctl.evict = 1'b1;
				state_d   = ptlr_pkg::S_FINISH;
			end
			ptlr_pkg::S_FINISH: begin
				ctl.finish = 1'b1;
				state_d    = ptlr_pkg::S_OUT;
			end
			ptlr_pkg::S_OUT: begin
				if (!out_stall) state_d = ptlr_pkg::S_IDLE;
			end
			default: state_d = ptlr_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ptlr_pkg::S_IDLE;
			use_free_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			use_free_q <= use_free_d;
		end
	end
endmodule

// ===== hdl/ptlr_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptlr_datapath: page table stores, frame pool, stamp clock and result
// Entry store is a memory with one port; residency bits live in flops.
// ----------------------------------------------------------------------------
module ptlr_datapath #(
	parameter int NUM_TABLES      = 4,
	parameter int PAGES_PER_TABLE = 64,
	parameter int PAGE_BYTES      = 4,
	parameter int NUM_FRAMES      = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  ptlr_pkg::req_t req,
	input  ptlr_pkg::ctl_t ctl,
	output ptlr_pkg::sts_t sts,
	output ptlr_pkg::rsp_t rsp
);
	localparam int NUM_ENTRIES = NUM_TABLES * PAGES_PER_TABLE;
	localparam int EW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
	localparam int FW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
	localparam int PW = (PAGES_PER_TABLE > 1) ? $clog2(PAGES_PER_TABLE) : 1;
	localparam int OW = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;
	localparam int OSH = $clog2(PAGE_BYTES);
	localparam int TW = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
	localparam int VLIM = PAGES_PER_TABLE * PAGE_BYTES;

	// memory word: frame, stamp, prot, owner
	typedef struct packed {
		logic [FW-1:0] frame;
		logic [31:0]   stamp;
		logic [2:0]    prot;
		logic [1:0]    owner;
	} ent_t;

	ent_t mem [NUM_ENTRIES];
	logic [NUM_ENTRIES-1:0] valid_q, dirty_q, wr_q;  // wr_q: entry written once
	logic [NUM_FRAMES-1:0]  used_q;
	logic [31:0]            clock_q;

	ptlr_pkg::req_t req_q;
	ent_t           ent_q, rd_q;
	logic [EW-1:0]  e_q;
	logic [OW-1:0]  off_q;
	logic           oob_q;

	logic [EW:0]    scan_q;
	logic [EW-1:0]  victim_q;
	logic [31:0]    min_q;
	logic           found_q;
	logic [FW-1:0]  free_q;

	// index arithmetic for the request being latched
	logic [15:0] page_w;
	logic [EW-1:0] e_w;
	always_comb begin
		page_w = 16'(req.virt_addr >> OSH);
		e_w    = EW'(32'(req.table_index) * PAGES_PER_TABLE + 32'(page_w));
	end

	// entry read port address
	logic [EW-1:0] raddr;
	always_comb begin
		if (ctl.escan)      raddr = scan_q[EW-1:0];
		else if (ctl.evict) raddr = victim_q;
		else                raddr = e_q;
	end

	logic [EW-1:0] rd_idx_q;
	ent_t rd_ent;
	always_comb begin
		rd_ent = rd_q;
		if (!wr_q[rd_idx_q]) rd_ent = '0;
	end

	function automatic logic [9:0] baddr(input logic [EW-1:0] e);
		return 10'(32'(e) * PAGE_BYTES);
	endfunction

	// clocked memory access: read in scan/lookup/evict, write at finish
	ent_t wr_ent;
	logic [31:0] st1, st2;
	logic        fault_w;
	logic [FW-1:0] new_frame;
	always_comb begin
		fault_w   = !valid_q[e_q];
		st1       = clock_q + 32'd1;
		st2       = fault_w ? clock_q + 32'd2 : clock_q + 32'd1;
		new_frame = ctl.use_free ? free_q : (found_q ? rd_ent.frame : '0);
		wr_ent    = ent_q;
		if (req_q.cmd == ptlr_pkg::CMD_LOAD) begin
			wr_ent.prot  = req_q.protection;
			wr_ent.owner = req_q.process_id;
		end else begin
			if (fault_w) wr_ent.frame = new_frame;
			wr_ent.stamp = st2;
		end
	end

	logic active_w;
	assign active_w = !oob_q && (req_q.cmd == ptlr_pkg::CMD_LOAD || ent_q.owner == req_q.process_id);

	always_ff @(posedge clk) begin
		if (ctl.lookup || ctl.escan || ctl.evict) begin
			rd_q     <= mem[raddr];
			rd_idx_q <= raddr;
		end
		if (ctl.finish && active_w) mem[e_q] <= wr_ent;
		if (ctl.evict && found_q) begin
			// victim stamp update is not stored
		end
	end

	// the victim's memory stamp is not rewritten when the victim is evicted:
	// since victim becomes invalid, its stamp is never compared until valid again,
	// and revalidation always rewrites the stamp, so the update is not stored.

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			req_q <= req;
			e_q   <= e_w;
			off_q <= OW'(req.virt_addr & 16'(PAGE_BYTES - 1));
			oob_q <= (32'(req.table_index) >= NUM_TABLES) || (32'(req.virt_addr) >= VLIM);
		end
		if (ctl.finish) begin
			rsp <= '0;
			if (oob_q) rsp.status <= ptlr_pkg::ST_BOUNDS;
			else if (req_q.cmd != ptlr_pkg::CMD_LOAD) begin
				if (ent_q.owner != req_q.process_id) rsp.status <= ptlr_pkg::ST_OWNER;
				else begin
					rsp.phys_addr <= 7'(32'(fault_w ? new_frame : ent_q.frame) * PAGE_BYTES
						+ 32'(off_q));
					if (!ent_q.prot[req_q.cmd])
						rsp.status <= ptlr_pkg::ST_DENY_RD + 3'(req_q.cmd);
					if (fault_w) begin
						rsp.page_fault    <= 1'b1;
						rsp.fill_aux_addr <= baddr(e_q);
						if (!ctl.use_free && found_q) begin
							rsp.evicted        <= 1'b1;
							rsp.writeback      <= dirty_q[victim_q];
							rsp.evict_aux_addr <= baddr(victim_q);
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.lookup) ent_q <= wr_q[e_q] ? mem[e_q] : '0;
	end

	// scans, residency, dirty, frame-use and stamp clock updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			dirty_q <= '0;
			wr_q    <= '0;
			used_q  <= '0;
			clock_q <= '0;
			scan_q  <= '0;
			found_q <= 1'b0;
			min_q   <= '0;
			victim_q <= '0;
			free_q  <= '0;
		end else begin
			if (ctl.scan_clr) begin
				scan_q  <= '0;
				found_q <= 1'b0;
			end else if (ctl.fscan) begin
				if (!used_q[scan_q[FW-1:0]]) free_q <= scan_q[FW-1:0];
				scan_q <= scan_q + 1'b1;
			end else if (ctl.escan) begin
				scan_q <= scan_q + 1'b1;
			end
			// compare the word read last cycle
			if (ctl.escan && scan_q != '0) begin
				if (valid_q[rd_idx_q] && (!found_q || rd_ent.stamp < min_q)) begin
					found_q  <= 1'b1;
					min_q    <= rd_ent.stamp;
					victim_q <= rd_idx_q;
				end
			end
			if (ctl.finish && active_w) begin
				wr_q[e_q] <= 1'b1;
				if (req_q.cmd != ptlr_pkg::CMD_LOAD) begin
					clock_q <= st2;
					if (fault_w) begin
						valid_q[e_q] <= 1'b1;
						if (ctl.use_free) used_q[free_q] <= 1'b1;
						else if (found_q) begin
							valid_q[victim_q] <= 1'b0;
							dirty_q[victim_q] <= 1'b0;
						end
					end
					dirty_q[e_q] <= (fault_w ? 1'b0 : dirty_q[e_q]) ||
						(req_q.cmd == ptlr_pkg::CMD_WRITE && ent_q.prot[req_q.cmd]);
				end
			end
		end
	end

	logic fscan_end, escan_end;
	assign fscan_end = (scan_q == (EW+1)'(NUM_FRAMES - 1));
	assign escan_end = (scan_q == (EW+1)'(NUM_ENTRIES));

	always_comb begin
		sts.oob        = oob_q;
		sts.is_load    = (req_q.cmd == ptlr_pkg::CMD_LOAD);
		sts.not_owner  = (ent_q.owner != req_q.process_id);
		sts.resident   = valid_q[e_q];
		sts.fscan_hit  = !used_q[scan_q[FW-1:0]];
		sts.fscan_done = fscan_end;
		sts.escan_done = escan_end;
	end

	logic unused_ok;
	assign unused_ok = ^{TW, PW, st1};
endmodule

// ===== hdl/page_translate_lru_replace.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_translate_lru_replace: page translation with LRU frame replacement
//
// A request beat (req) carries a command, process, table, virtual address and
// protection. One response beat (rsp) is returned per request: status,
// physical address and fault/eviction information.
// One request is in flight at a time; in_stall is high from acceptance until
// the response beat is taken. A hit, load or refused access passes through
// lookup, check and finish before its response is presented, and the next
// request can be taken once the response has been taken. A fault with a free
// frame adds a frame scan; a fault with no free frame adds the frame scan, an
// oldest-stamp scan over the single-port entry memory and a victim read.
// Reset clears residency, dirty and frame-use bits and the stamp clock; the
// entry memory needs no clearing pass, unwritten entries read as zero.
// While out_stall is high the response beat holds and no request is taken.
// ----------------------------------------------------------------------------
module page_translate_lru_replace #(
	parameter int NUM_TABLES      = 4,
	parameter int PAGES_PER_TABLE = 64,
	parameter int PAGE_BYTES      = 4,
	parameter int NUM_FRAMES      = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  ptlr_pkg::req_t req,
	output logic           out_valid,
	input  logic           out_stall,
	output ptlr_pkg::rsp_t rsp
);
	ptlr_pkg::ctl_t ctl;
	ptlr_pkg::sts_t sts;

	ptlr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall),
		.sts(sts), .ctl(ctl)
	);

	ptlr_datapath #(
		.NUM_TABLES(NUM_TABLES), .PAGES_PER_TABLE(PAGES_PER_TABLE),
		.PAGE_BYTES(PAGE_BYTES), .NUM_FRAMES(NUM_FRAMES)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .req(req), .ctl(ctl), .sts(sts), .rsp(rsp)
	);

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.capture, ctl.lookup, ctl.finish, ctl.evict}))
		else $error("datapath commands overlap");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("request taken while response pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(rsp))
		else $error("stalled response changed");
endmodule
